>>> sv/mapb_pkg.sv
// Shared types and constants of the memory address pattern self-test block.
package mapb_pkg;

  // Line size in bytes; region address and size must be multiples of it.
  // Must be a power of two between 4 and 256.
  localparam int unsigned LINE_BYTES = 32;
  localparam int unsigned LINE_LSB   = $clog2(LINE_BYTES);

  // Base value of the address XOR pattern
  localparam logic [31:0] PATTERN = 32'hA5A5A5A5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_READY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BYTES = 2'd2;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_READ   = 3'd2,
    OP_SYNC   = 3'd3,
    OP_FINISH = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_INVALID_STATE = 3'd1,
    ST_OUT_OF_RANGE  = 3'd2,
    ST_INVALID_ARG   = 3'd3,
    ST_IO_ERROR      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_WRITE1 = 4'd1,
    PH_SYNC1  = 4'd2,
    PH_READ1  = 4'd3,
    PH_WRITE2 = 4'd4,
    PH_SYNC2  = 4'd5,
    PH_READ2  = 4'd6,
    PH_ZERO   = 4'd7,
    PH_SYNC3  = 4'd8,
    PH_FINISH = 4'd9
  } phase_t;

endpackage

>>> sv/mapb_in_if.sv
// Request channel of the memory address pattern self-test block.
interface mapb_in_if;
  logic              valid;
  logic              ready;
  mapb_pkg::req_t    req_type;
  logic [31:0]       region_start;
  logic [31:0]       region_bytes;
  logic [31:0]       read_word;

  modport source (output valid, output req_type, output region_start,
                  output region_bytes, output read_word, input ready);
  modport sink   (input valid, input req_type, input region_start,
                  input region_bytes, input read_word, output ready);
endinterface

>>> sv/mapb_out_if.sv
// Result channel of the memory address pattern self-test block.
interface mapb_out_if;
  logic              valid;
  logic              ready;
  mapb_pkg::op_t     op;
  logic [31:0]       mem_address;
  logic [31:0]       write_word;
  mapb_pkg::status_t status;
  logic              done_res;

  modport source (output valid, output op, output mem_address, output write_word,
                  output status, output done_res, input ready);
  modport sink   (input valid, input op, input mem_address, input write_word,
                  input status, input done_res, output ready);
endinterface

>>> sv/mapb_cfg_if.sv
// Configuration write channel of the memory address pattern self-test block.
interface mapb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mapb_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/memory_address_pattern_bist.sv
// Top level of the memory address pattern self-test sequencer.
//
// Usage: a start request (req_type 0) names a byte region; the block checks
// memory_ready, the test window and line alignment. A failed check returns a
// finished result with the error status at once; a passing one returns op
// none. Each advance request (req_type 1) then yields one memory operation:
// pattern writes, sync, read-back, inverted pass, zero fill, sync, finished.
// Read data for a read result comes with the next advance request.
// Channels: in_ch (requests), out_ch (one result per request), cfg_ch
// (register writes, always ready, to be used only while the block is idle).
// Pipeline: a request is captured in the request register, and its result is
// written to the result register once that register is empty or being taken.
// Throughput: one request per cycle unless out_ch stalls, set by the
// single sequencer pass between the request register and the result register.
// Reset: the sequencer returns to idle, configuration registers clear to zero,
// both pipeline stages empty. When the receiver stalls, the result is held, one
// more request is captured, and in_ch.ready then drops until the result is taken.
module memory_address_pattern_bist_core (
  input  logic        clk,
  input  logic        rst_n,
  mapb_in_if.sink     in_ch,
  mapb_out_if.source  out_ch,
  mapb_cfg_if.sink    cfg_ch
);

  // Configuration registers
  logic        memory_ready_r;
  logic [31:0] window_base_r;
  logic [31:0] window_bytes_r;

  // Request register
  logic           in_valid_r;
  mapb_pkg::req_t req_type_r;
  logic [31:0]    region_start_r;
  logic [31:0]    region_bytes_r;
  logic [31:0]    read_word_r;

  // Sequencer state
  mapb_pkg::phase_t  phase_r, phase_nxt;
  logic [29:0]       word_index_r, word_index_nxt;
  logic [29:0]       word_total_r, word_total_nxt;
  logic [31:0]       region_base_r, region_base_nxt;
  mapb_pkg::status_t test_status_r, test_status_nxt;
  logic              check_pending_r, check_pending_nxt;
  logic [31:0]       expected_word_r, expected_word_nxt;

  // Result register
  logic              out_valid_r;
  mapb_pkg::op_t     op_r, op_nxt;
  logic [31:0]       mem_address_r, mem_address_nxt;
  logic [31:0]       write_word_r, write_word_nxt;
  mapb_pkg::status_t status_r, status_nxt;
  logic              done_r, done_nxt;

  logic fire;
  logic in_accept;

  // Start checks
  logic [31:0]       win_offset;
  logic [31:0]       win_room;
  logic              in_window;
  logic              misaligned;
  mapb_pkg::status_t start_err;

  // Phase and index after the read check and end-of-pass step
  mapb_pkg::phase_t eff_phase;
  logic [29:0]      eff_index;
  logic [29:0]      index_inc;
  logic             index_wrap;
  logic [31:0]      word_addr;
  logic [31:0]      word_pat;

  // Handshakes: result register frees when empty or taken
  assign fire         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || fire;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      memory_ready_r <= 1'b0;
      window_base_r  <= '0;
      window_bytes_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        mapb_pkg::CFG_MEMORY_READY: memory_ready_r <= cfg_ch.data[0];
        mapb_pkg::CFG_WINDOW_BASE:  window_base_r  <= cfg_ch.data;
        mapb_pkg::CFG_WINDOW_BYTES: window_bytes_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Capture requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_type_r     <= in_ch.req_type;
      region_start_r <= in_ch.region_start;
      region_bytes_r <= in_ch.region_bytes;
      read_word_r    <= in_ch.read_word;
    end
  end

  // Check the region against the window and the line size
  always_comb begin
    win_offset = region_start_r - window_base_r;
    win_room   = window_bytes_r - win_offset;
    in_window  = (region_bytes_r != '0) && (region_start_r >= window_base_r) &&
                 (win_offset < window_bytes_r) && (region_bytes_r <= win_room);
    misaligned = (region_start_r[mapb_pkg::LINE_LSB-1:0] != '0) ||
                 (region_bytes_r[mapb_pkg::LINE_LSB-1:0] != '0);
    if (!memory_ready_r) begin
      start_err = mapb_pkg::ST_INVALID_STATE;
    end else if (!in_window) begin
      start_err = mapb_pkg::ST_OUT_OF_RANGE;
    end else if (misaligned) begin
      start_err = mapb_pkg::ST_INVALID_ARG;
    end else begin
      start_err = mapb_pkg::ST_OK;
    end
  end

  // Resolve pending read check and end of a read pass
  always_comb begin
    eff_phase = phase_r;
    eff_index = word_index_r;
    if ((phase_r == mapb_pkg::PH_READ1 || phase_r == mapb_pkg::PH_READ2) &&
        check_pending_r && (read_word_r != expected_word_r)) begin
      eff_phase = mapb_pkg::PH_ZERO;
      eff_index = '0;
    end
    if ((eff_phase == mapb_pkg::PH_READ1 || eff_phase == mapb_pkg::PH_READ2) &&
        (eff_index >= word_total_r)) begin
      eff_phase = (eff_phase == mapb_pkg::PH_READ1) ? mapb_pkg::PH_WRITE2
                                                    : mapb_pkg::PH_ZERO;
      eff_index = '0;
    end
    index_inc  = eff_index + 30'd1;
    index_wrap = (index_inc >= word_total_r);
    word_addr  = region_base_r + {eff_index, 2'b00};
    word_pat   = word_addr ^ mapb_pkg::PATTERN;
  end

  // Next sequencer state
  always_comb begin
    phase_nxt         = phase_r;
    word_index_nxt    = word_index_r;
    word_total_nxt    = word_total_r;
    region_base_nxt   = region_base_r;
    test_status_nxt   = test_status_r;
    check_pending_nxt = check_pending_r;
    expected_word_nxt = expected_word_r;
    if (req_type_r == mapb_pkg::REQ_START) begin
      phase_nxt         = mapb_pkg::PH_IDLE;
      word_index_nxt    = '0;
      word_total_nxt    = '0;
      test_status_nxt   = mapb_pkg::ST_OK;
      check_pending_nxt = 1'b0;
      expected_word_nxt = '0;
      if (start_err == mapb_pkg::ST_OK) begin
        region_base_nxt = region_start_r;
        word_total_nxt  = region_bytes_r[31:2];
        phase_nxt       = mapb_pkg::PH_WRITE1;
      end
    end else begin
      if ((phase_r == mapb_pkg::PH_READ1 || phase_r == mapb_pkg::PH_READ2) &&
          check_pending_r) begin
        check_pending_nxt = 1'b0;
        if (read_word_r != expected_word_r) begin
          test_status_nxt = mapb_pkg::ST_IO_ERROR;
        end
      end
      phase_nxt      = eff_phase;
      word_index_nxt = eff_index;
      unique case (eff_phase)
        mapb_pkg::PH_WRITE1, mapb_pkg::PH_WRITE2, mapb_pkg::PH_ZERO: begin
          word_index_nxt = index_wrap ? 30'd0 : index_inc;
          if (index_wrap) begin
            phase_nxt = (eff_phase == mapb_pkg::PH_WRITE1) ? mapb_pkg::PH_SYNC1 :
                        (eff_phase == mapb_pkg::PH_WRITE2) ? mapb_pkg::PH_SYNC2 :
                                                             mapb_pkg::PH_SYNC3;
          end
        end
        mapb_pkg::PH_SYNC1, mapb_pkg::PH_SYNC2, mapb_pkg::PH_SYNC3: begin
          word_index_nxt = '0;
          phase_nxt = (eff_phase == mapb_pkg::PH_SYNC1) ? mapb_pkg::PH_READ1 :
                      (eff_phase == mapb_pkg::PH_SYNC2) ? mapb_pkg::PH_READ2 :
                                                          mapb_pkg::PH_FINISH;
        end
        mapb_pkg::PH_READ1, mapb_pkg::PH_READ2: begin
          expected_word_nxt = (eff_phase == mapb_pkg::PH_READ2) ? ~word_pat : word_pat;
          check_pending_nxt = 1'b1;
          word_index_nxt    = index_inc;
        end
        mapb_pkg::PH_FINISH: begin
          phase_nxt         = mapb_pkg::PH_IDLE;
          word_index_nxt    = '0;
          check_pending_nxt = 1'b0;
        end
        default: begin
          phase_nxt = mapb_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Result of the current request
  always_comb begin
    op_nxt          = mapb_pkg::OP_NONE;
    mem_address_nxt = '0;
    write_word_nxt  = '0;
    status_nxt      = mapb_pkg::ST_OK;
    done_nxt        = 1'b0;
    if (req_type_r == mapb_pkg::REQ_START) begin
      if (start_err != mapb_pkg::ST_OK) begin
        op_nxt     = mapb_pkg::OP_FINISH;
        status_nxt = start_err;
        done_nxt   = 1'b1;
      end
    end else begin
      unique case (eff_phase)
        mapb_pkg::PH_WRITE1: begin
          op_nxt          = mapb_pkg::OP_WRITE;
          mem_address_nxt = word_addr;
          write_word_nxt  = word_pat;
        end
        mapb_pkg::PH_WRITE2: begin
          op_nxt          = mapb_pkg::OP_WRITE;
          mem_address_nxt = word_addr;
          write_word_nxt  = ~word_pat;
        end
        mapb_pkg::PH_ZERO: begin
          op_nxt          = mapb_pkg::OP_WRITE;
          mem_address_nxt = word_addr;
        end
        mapb_pkg::PH_SYNC1, mapb_pkg::PH_SYNC2, mapb_pkg::PH_SYNC3: begin
          op_nxt          = mapb_pkg::OP_SYNC;
          mem_address_nxt = region_base_r;
        end
        mapb_pkg::PH_READ1, mapb_pkg::PH_READ2: begin
          op_nxt          = mapb_pkg::OP_READ;
          mem_address_nxt = word_addr;
        end
        mapb_pkg::PH_FINISH: begin
          op_nxt     = mapb_pkg::OP_FINISH;
          status_nxt = test_status_nxt;
          done_nxt   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Advance sequencer state on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= mapb_pkg::PH_IDLE;
      word_index_r    <= '0;
      test_status_r   <= mapb_pkg::ST_OK;
      check_pending_r <= 1'b0;
    end else if (fire) begin
      phase_r         <= phase_nxt;
      word_index_r    <= word_index_nxt;
      test_status_r   <= test_status_nxt;
      check_pending_r <= check_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      word_total_r    <= word_total_nxt;
      region_base_r   <= region_base_nxt;
      expected_word_r <= expected_word_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      op_r          <= op_nxt;
      mem_address_r <= mem_address_nxt;
      write_word_r  <= write_word_nxt;
      status_r      <= status_nxt;
      done_r        <= done_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.op          = op_r;
  assign out_ch.mem_address = mem_address_r;
  assign out_ch.write_word  = write_word_r;
  assign out_ch.status      = status_r;
  assign out_ch.done_res    = done_r;

`ifndef SYNTHESIS
  // A running test always has a nonzero word count
  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != mapb_pkg::PH_IDLE |-> word_total_r != '0)
    else $error("active test with zero word count");

  // A pending read check only exists inside a read pass
  a_pending_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    check_pending_r |-> (phase_r == mapb_pkg::PH_READ1 || phase_r == mapb_pkg::PH_READ2))
    else $error("read check pending outside a read pass");

  // Write passes never run past the last word
  a_write_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == mapb_pkg::PH_WRITE1 || phase_r == mapb_pkg::PH_WRITE2 ||
     phase_r == mapb_pkg::PH_ZERO) |-> word_index_r < word_total_r)
    else $error("write index beyond region");

  // An advance in the finish phase yields a finished result and returns to idle
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req_type_r == mapb_pkg::REQ_ADVANCE && phase_r == mapb_pkg::PH_FINISH
    |=> out_valid_r && done_r && op_r == mapb_pkg::OP_FINISH &&
        phase_r == mapb_pkg::PH_IDLE)
    else $error("finish phase did not report finished");
`endif

endmodule
